[rtl/anr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// anr_pkg
// shared types and constants of the affine nearest-pixel remap block
// ----------------------------------------------------------------------------
package anr_pkg;

  localparam int TOP_W = 48;
  localparam int DET_W = 33;
  localparam int IDX_W = 8;

  localparam logic [IDX_W-1:0] REG_COEF_A     = 8'd0;
  localparam logic [IDX_W-1:0] REG_COEF_B     = 8'd1;
  localparam logic [IDX_W-1:0] REG_COEF_C     = 8'd2;
  localparam logic [IDX_W-1:0] REG_COEF_D     = 8'd3;
  localparam logic [IDX_W-1:0] REG_SHIFT_X    = 8'd4;
  localparam logic [IDX_W-1:0] REG_SHIFT_Y    = 8'd5;
  localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 8'd6;
  localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 8'd7;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic        valid;
    logic        func;
    logic        singular;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [23:0] pixel;
  } side_t;

endpackage
`default_nettype wire

[rtl/anr_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// anr_ram
// single-port ram with registered read and a clock enable
// ----------------------------------------------------------------------------
module anr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

[rtl/anr_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// anr_div
// pipelined truncating divide of top by det*256, one quotient bit per stage;
// ok is set only when the quotient lies in 0 .. 2**QW-1
// ----------------------------------------------------------------------------
module anr_div #(
  parameter int QW = 8
) (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic signed [anr_pkg::TOP_W-1:0] top,
  input  wire logic signed [anr_pkg::DET_W-1:0] det,
  output logic                                 ok,
  output logic             [QW-1:0]            quo
);
  import anr_pkg::*;

  localparam int BW = DET_W + 8;
  localparam int RW = TOP_W + QW;

  logic [TOP_W-1:0] mt;
  logic [BW-1:0]    mb;
  logic             neg;
  logic             nz;

  logic [RW-1:0] rem  [QW];
  logic [RW-1:0] mbs  [QW];
  logic [QW-1:0] qs   [QW+1];
  logic          oks  [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      mt  <= top[TOP_W-1] ? TOP_W'(-top) : TOP_W'(top);
      mb  <= BW'(det[DET_W-1] ? DET_W'(-det) : DET_W'(det)) << 8;
      neg <= (top[TOP_W-1] ^ det[DET_W-1]) && (top != '0);
      nz  <= det != '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oks[0] <= nz && (RW'(mt) < (RW'(mb) << QW)) && !(neg && (RW'(mt) >= RW'(mb)));
      rem[0] <= RW'(mt);
      mbs[0] <= RW'(mb);
      qs[0]  <= '0;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [RW-1:0] trial;
    logic          fit;
    assign trial = mbs[i] << (QW - 1 - i);
    assign fit   = rem[i] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        oks[i+1] <= oks[i];
        qs[i+1]  <= qs[i] | (fit ? (QW'(1) << (QW - 1 - i)) : '0);
      end
    end
    if (i < QW - 1) begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i+1] <= fit ? rem[i] - trial : rem[i];
          mbs[i+1] <= mbs[i];
        end
      end
    end
  end

  assign ok  = oks[QW];
  assign quo = qs[QW];

endmodule
`default_nettype wire

[rtl/affine_nearest_remap_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// affine_nearest_remap_top
// inverse-mapped affine warp with nearest-pixel pick from a frame store
//
//   channel  handshake         payload
//   s        s_tvalid/tready   s_tdata pixel request, s_tuser func
//   m        m_tvalid/tready   m_tdata color, m_tuser covered/singular
//   cfg      cfg_valid/ready   cfg_index, cfg_data
//
// one request per cycle while the output is not stalled; a query passes the product,
// determinant, shift and dividend stages, the bit-per-stage divider pipeline and the
// store access stage; loads write the store in the same stage queries read it, so order holds
// one enable moves all stages; a stalled output freezes the whole pipe
// rst clears valid bits and output flags and resets the config registers; the store is not cleared
// ----------------------------------------------------------------------------
module affine_nearest_remap_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [39:0]               s_tdata,   // pos_x, pos_y, in_blue, in_green, in_red
  input  wire logic                      s_tuser,   // func
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic      [23:0]               m_tdata,   // out_blue, out_green, out_red
  output logic      [1:0]                m_tuser,   // covered, singular
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [anr_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [15:0]               cfg_data
);
  import anr_pkg::*;

  localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int QW    = $clog2(MAXD);
  localparam int CW    = ((QW > 9) ? QW : 9) + 1;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int LAT   = QW + 2;

  logic signed [15:0] coef_a, coef_b, coef_c, coef_d, shift_x, shift_y;
  logic        [8:0]  src_width, src_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a     <= 16'sd256;
      coef_b     <= '0;
      coef_c     <= '0;
      coef_d     <= 16'sd256;
      shift_x    <= '0;
      shift_y    <= '0;
      src_width  <= 9'd256;
      src_height <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COEF_A:     coef_a     <= cfg_data;
        REG_COEF_B:     coef_b     <= cfg_data;
        REG_COEF_C:     coef_c     <= cfg_data;
        REG_COEF_D:     coef_d     <= cfg_data;
        REG_SHIFT_X:    shift_x    <= cfg_data;
        REG_SHIFT_Y:    shift_y    <= cfg_data;
        REG_SRC_WIDTH:  src_width  <= cfg_data[8:0];
        REG_SRC_HEIGHT: src_height <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  logic en;
  logic ov, ocov, osing;
  logic [23:0] rdata;

  assign en       = !ov || m_tready;
  assign s_tready = en;

  // stage 1: products
  side_t s1, s2, s3, s4;
  logic signed [31:0] ad1, bc1;
  logic signed [24:0] dx1, by1, cx1, ay1;
  logic signed [8:0]  xs, ys;

  assign xs = $signed({1'b0, s_tdata[7:0]});
  assign ys = $signed({1'b0, s_tdata[15:8]});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else if (en) begin
      s1 <= '{valid: s_tvalid, func: s_tuser, singular: 1'b0,
              pos_x: s_tdata[7:0], pos_y: s_tdata[15:8], pixel: s_tdata[39:16]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ad1 <= 32'(coef_a * coef_d);
      bc1 <= 32'(coef_b * coef_c);
      dx1 <= 25'(coef_d * xs);
      by1 <= 25'(coef_b * ys);
      cx1 <= 25'(coef_c * xs);
      ay1 <= 25'(coef_a * ys);
    end
  end

  // stage 2: determinant and numerators
  logic signed [DET_W-1:0] det2, det3, det4;
  logic signed [25:0]      nx2, ny2, nx3, ny3;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2 <= '0;
    end else if (en) begin
      s2 <= s1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det2 <= DET_W'(ad1) - DET_W'(bc1);
      nx2  <= 26'(dx1) - 26'(by1);
      ny2  <= 26'(ay1) - 26'(cx1);
    end
  end

  // stage 3: shift times determinant
  logic signed [48:0] tx3, ty3;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3 <= '0;
    end else if (en) begin
      s3 <= s2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tx3  <= 49'(shift_x * det2);
      ty3  <= 49'(shift_y * det2);
      nx3  <= nx2;
      ny3  <= ny2;
      det3 <= det2;
    end
  end

  // stage 4: dividends
  logic signed [TOP_W-1:0] topx4, topy4;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4 <= '0;
    end else if (en) begin
      s4 <= '{valid: s3.valid, func: s3.func, singular: det3 == '0,
              pos_x: s3.pos_x, pos_y: s3.pos_y, pixel: s3.pixel};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      topx4 <= (TOP_W'(nx3) <<< 16) - TOP_W'(tx3);
      topy4 <= (TOP_W'(ny3) <<< 16) - TOP_W'(ty3);
      det4  <= det3;
    end
  end

  // divider stages
  logic          okx, oky;
  logic [QW-1:0] qx, qy;

  anr_div #(.QW(QW)) u_div_x (
    .clk (clk), .en (en), .top (topx4), .det (det4), .ok (okx), .quo (qx)
  );

  anr_div #(.QW(QW)) u_div_y (
    .clk (clk), .en (en), .top (topy4), .det (det4), .ok (oky), .quo (qy)
  );

  side_t side [LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      side[0] <= '0;
    end else if (en) begin
      side[0] <= s4;
    end
  end

  for (genvar i = 1; i < LAT; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        side[i] <= '0;
      end else if (en) begin
        side[i] <= side[i-1];
      end
    end
  end

  // store access stage
  side_t          sl;
  logic [CW-1:0]  qxe, qye, lxe, lye;
  logic           cov, ld_ok, we;
  logic [AW-1:0]  addr;
  logic [AW-1:0]  col, row;

  assign sl    = side[LAT-1];
  assign qxe   = CW'(qx);
  assign qye   = CW'(qy);
  assign lxe   = CW'(sl.pos_x);
  assign lye   = CW'(sl.pos_y);
  assign cov   = okx && oky && !sl.singular
              && (qxe < CW'(src_width))  && (qxe < CW'(MAX_WIDTH))
              && (qye < CW'(src_height)) && (qye < CW'(MAX_HEIGHT));
  assign ld_ok = (lxe < CW'(MAX_WIDTH)) && (lye < CW'(MAX_HEIGHT));
  assign we    = en && sl.valid && (sl.func == FUNC_LOAD) && ld_ok;
  assign col   = (sl.func == FUNC_QUERY) ? AW'(qx) : AW'(sl.pos_x);
  assign row   = (sl.func == FUNC_QUERY) ? AW'(qy) : AW'(sl.pos_y);
  assign addr  = AW'(row * AW'(MAX_WIDTH)) + col;

  anr_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_store (
    .clk (clk), .en (en), .we (we), .addr (addr), .wdata (sl.pixel), .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ov    <= 1'b0;
      ocov  <= 1'b0;
      osing <= 1'b0;
    end else if (en) begin
      ov    <= sl.valid && (sl.func == FUNC_QUERY);
      ocov  <= cov;
      osing <= sl.singular;
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = ocov ? rdata : '0;
  assign m_tuser  = {osing, ocov};

  a_sing_uncov: assert property (@(posedge clk) disable iff (rst)
    ov && osing |-> !ocov)
    else $error("singular result marked covered");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    ov && !m_tready |=> ov && $stable(ocov) && $stable(osing))
    else $error("stalled result changed");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(sl))
    else $error("pipeline moved during stall");

endmodule
`default_nettype wire
